FILE: sv/pebd_pkg.sv
// Shared types and character constants for the percent-escaped base64 decoder.
// No dependencies; used by pebd_decode, pebd_burst_out and the top level.

package pebd_pkg;

  localparam logic [7:0] CharEquals  = 8'h3D;  // '='
  localparam logic [7:0] CharPlus    = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash   = 8'h2F;  // '/'
  localparam logic [7:0] CharLowZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CharPercent = 8'h25;  // '%'

  localparam int unsigned BurstDepth = 2;      // bursts held between decode and output

  // Escape decoding phase.
  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscHigh = 2'd1,
    EscLow  = 2'd2
  } esc_phase_e;

  // Up to three results caused by one input beat.
  typedef struct packed {
    logic [2:0][7:0] data;    // data[0] goes out first
    logic [1:0]      count;   // number of results, 1 to 3
    logic            marker;  // single result without data
    logic            done;    // last result closes the string
  } burst_t;

endpackage

FILE: sv/pebd_decode.sv
// Escape handling, base64 sextet mapping and group packing for one input beat.
// Depends on pebd_pkg; produces at most one burst of results per accepted beat.

module pebd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_string_i,
  output logic              push_o,
  output pebd_pkg::burst_t  burst_o
);

  // Returns {valid, value} for a hexadecimal digit of either case.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Returns {valid, sextet}; characters outside '+'..'z' never map.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:pebd_pkg::CharLowZ]}) begin
      r = {1'b1, 6'(c - 8'h47)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c + 8'h04)};
    end else if (c == pebd_pkg::CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == pebd_pkg::CharSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  logic [23:0]           group_q, group_d;
  logic [1:0]            count_q, count_d;
  pebd_pkg::esc_phase_e  phase_q, phase_d;
  logic [3:0]            nibble_q, nibble_d;
  logic                  stopped_q, stopped_d;

  logic [4:0]  hex;
  logic [6:0]  sext;
  logic [7:0]  ch;
  logic [23:0] merged;
  logic [1:0]  flush_n;

  assign hex     = hex_value(in_char_i);
  assign ch      = (phase_q == pebd_pkg::EscLow) ? {nibble_q, hex[3:0]} : in_char_i;
  assign sext    = sextet_value(ch);
  assign flush_n = (count_q > 2'd1) ? 2'(count_q - 2'd1) : 2'd0;

  always_comb begin
    merged = group_q;
    case (count_q)
      2'd0:    merged[23:18] = sext[5:0];
      2'd1:    merged[17:12] = sext[5:0];
      2'd2:    merged[11:6]  = sext[5:0];
      default: merged[5:0]   = sext[5:0];
    endcase
  end

  always_comb begin
    group_d        = group_q;
    count_d        = count_q;
    phase_d        = phase_q;
    nibble_d       = nibble_q;
    stopped_d      = stopped_q;
    push_o         = 1'b0;
    burst_o.data   = {group_q[7:0], group_q[15:8], group_q[23:16]};
    burst_o.count  = flush_n;
    burst_o.marker = 1'b0;
    burst_o.done   = 1'b0;

    if (end_of_string_i) begin
      push_o       = accept_i;
      burst_o.done = 1'b1;
      if (stopped_q || flush_n == 2'd0) begin
        burst_o.count  = 2'd1;
        burst_o.marker = 1'b1;
        burst_o.data   = '0;
      end
      group_d   = '0;
      count_d   = '0;
      phase_d   = pebd_pkg::EscNone;
      nibble_d  = '0;
      stopped_d = 1'b0;
    end else if (!stopped_q) begin
      if ((phase_q != pebd_pkg::EscNone && !hex[4]) ||
          (!(phase_q == pebd_pkg::EscNone && in_char_i == pebd_pkg::CharPercent) &&
           phase_q != pebd_pkg::EscHigh && !sext[6])) begin
        // Bad escape digit or a character with no sextet: flush and stop.
        push_o    = accept_i && (flush_n != 2'd0);
        group_d   = '0;
        count_d   = '0;
        phase_d   = pebd_pkg::EscNone;
        nibble_d  = '0;
        stopped_d = 1'b1;
      end else if (phase_q == pebd_pkg::EscHigh) begin
        nibble_d = hex[3:0];
        phase_d  = pebd_pkg::EscLow;
      end else if (phase_q == pebd_pkg::EscNone && in_char_i == pebd_pkg::CharPercent) begin
        phase_d = pebd_pkg::EscHigh;
      end else begin
        phase_d  = pebd_pkg::EscNone;
        nibble_d = '0;
        if (count_q == 2'd3) begin
          push_o        = accept_i;
          burst_o.data  = {merged[7:0], merged[15:8], merged[23:16]};
          burst_o.count = 2'd3;
          group_d       = '0;
          count_d       = '0;
        end else begin
          group_d = merged;
          count_d = 2'(count_q + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q   <= '0;
      count_q   <= '0;
      phase_q   <= pebd_pkg::EscNone;
      nibble_q  <= '0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      group_q   <= group_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      nibble_q  <= nibble_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

FILE: sv/pebd_burst_out.sv
// Depth-entry burst queue (two by default) and the serialiser that hands its results out one beat at a time.
// Depends on pebd_pkg for the burst type and queue depth.

module pebd_burst_out #(
  parameter int unsigned Depth = pebd_pkg::BurstDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pebd_pkg::burst_t  burst_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              last_of_run_o,
  output logic              stream_done_o
);

  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  pebd_pkg::burst_t  slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]  fill_q;
  logic [1:0]        idx_q;

  pebd_pkg::burst_t  head;
  logic              last_beat;
  logic              pop;

  assign head          = slot_q[rd_ptr_q];
  assign out_valid_o   = (fill_q != '0);
  assign full_o        = (fill_q == FillW'(Depth));
  assign last_beat     = (idx_q == 2'(head.count - 2'd1));
  assign pop           = out_valid_o && out_ready_i && last_beat;
  assign out_byte_o    = head.data[idx_q];
  assign byte_valid_o  = !head.marker;
  assign last_of_run_o = last_beat;
  assign stream_done_o = head.done && last_beat;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
        idx_q    <= '0;
      end else if (out_valid_o && out_ready_i) begin
        idx_q <= 2'(idx_q + 2'd1);
      end
      if (push_i && !pop) begin
        fill_q <= FillW'(fill_q + 1'b1);
      end else if (pop && !push_i) begin
        fill_q <= FillW'(fill_q - 1'b1);
      end
    end
  end

endmodule

FILE: sv/percent_escaped_base64_decoder.sv
// Top level of the percent-escaped base64 decoder.
// Depends on pebd_pkg, pebd_decode and pebd_burst_out.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------------
//   input   | in_valid_i/in_ready_o   | in_char_i, end_of_string_i
//   output  | out_valid_o/out_ready_i | out_byte_o, byte_valid_o, last_of_run_o, stream_done_o
//
// One input beat is decoded in the cycle it is accepted; its results are registered into the burst queue.
// Input beats are taken every cycle while the burst queue has a free entry.
// A full group or flush drains one result per cycle while out_ready_i is high; bursts of three set the rate.
// Reset clears the decode state and empties the queue; no clearing pass is needed.
// An output stall holds the current result; input is refused only once the queue is full.

module percent_escaped_base64_decoder #(
  parameter int unsigned BurstDepth = pebd_pkg::BurstDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_of_run_o,
  output logic        stream_done_o
);

  logic              accept;
  logic              push;
  logic              full;
  pebd_pkg::burst_t  burst;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  pebd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_char_i       (in_char_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (push),
    .burst_o         (burst)
  );

  pebd_burst_out #(
    .Depth (BurstDepth)
  ) u_burst_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .burst_i       (burst),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o)
  );

endmodule

FILE: sv/pebd_checker.sv
// Port-level checks for the percent-escaped base64 decoder, bound to the top level.
// Depends only on the top level's ports.

module pebd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        byte_valid_o,
  input logic        last_of_run_o,
  input logic        stream_done_o
);

  // A finished string always closes the run of results of its beat.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o)
    else $error("stream_done without last_of_run");

  // A result without data is only the bare completion marker of an end of string.
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> stream_done_o && last_of_run_o && out_byte_o == 8'h00)
    else $error("malformed completion marker");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

endmodule

bind percent_escaped_base64_decoder pebd_checker u_pebd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .byte_valid_o  (byte_valid_o),
  .last_of_run_o (last_of_run_o),
  .stream_done_o (stream_done_o)
);

FILE: verif/percent_escaped_base64_decoder_test.sv
// Self-checking testbench for the percent-escaped base64 decoder top level.
// Depends on pebd_pkg and percent_escaped_base64_decoder; a built-in decode model predicts
// every result beat, and random gaps and stalls are applied on both channels.

module percent_escaped_base64_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
  } decoded_byte_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i       = 8'h00;
  logic       end_of_string_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       last_of_run_o;
  logic       stream_done_o;

  percent_escaped_base64_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o)
  );

  char_beat_t    pending_chars[$];
  decoded_byte_t expected_bytes[$];
  int            beats_accepted = 0;
  int            total_beats    = 0;
  int            mismatches     = 0;
  int            send_gap       = 0;
  int            send_calm      = 0;
  int            recv_hold      = 0;
  int            recv_calm      = 0;

  // Decoder state as seen by the testbench.
  logic [23:0]          group_bits;
  int unsigned          group_count;
  pebd_pkg::esc_phase_e esc_phase;
  logic [3:0]           esc_high;
  bit                   stopped;

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == pebd_pkg::CharPlus) return 62;
    if (c == pebd_pkg::CharSlash) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] base64_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? pebd_pkg::CharPlus : pebd_pkg::CharSlash;
  endfunction

  function automatic logic [7:0] hex_char(int nibble, bit upper);
    if (nibble < 10) return 8'("0" + nibble);
    return upper ? 8'("A" + nibble - 10) : 8'("a" + nibble - 10);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int idle_length(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic clear_group();
    group_bits  = '0;
    group_count = 0;
    esc_phase   = pebd_pkg::EscNone;
    esc_high    = '0;
  endtask

  task automatic push_group_bytes(int n);
    decoded_byte_t b;
    for (int i = 0; i < n; i++) begin
      b.data  = group_bits[23 - 8 * i -: 8];
      b.valid = 1'b1;
      b.last  = (i == n - 1);
      b.done  = 1'b0;
      expected_bytes.push_back(b);
    end
  endtask

  task automatic stop_decoding();
    push_group_bytes(group_count > 1 ? group_count - 1 : 0);
    clear_group();
    stopped = 1'b1;
  endtask

  // Works out the result beats caused by one accepted input beat.
  task automatic decode_beat(logic [7:0] ch, logic eos);
    decoded_byte_t b;
    logic [7:0]    c;
    int            digit;
    int            six;
    int            n;
    c = ch;
    if (eos) begin
      n = (!stopped && group_count > 1) ? group_count - 1 : 0;
      if (n == 0) begin
        b = '{data: 8'h00, valid: 1'b0, last: 1'b1, done: 1'b1};
      end else begin
        push_group_bytes(n);
        b = expected_bytes.pop_back();
        b.done = 1'b1;
      end
      expected_bytes.push_back(b);
      clear_group();
      stopped = 1'b0;
      return;
    end
    if (stopped) return;
    if (esc_phase == pebd_pkg::EscHigh) begin
      digit = hex_value(c);
      if (digit < 0) begin
        stop_decoding();
        return;
      end
      esc_high  = digit[3:0];
      esc_phase = pebd_pkg::EscLow;
      return;
    end
    if (esc_phase == pebd_pkg::EscLow) begin
      digit = hex_value(c);
      if (digit < 0) begin
        stop_decoding();
        return;
      end
      // The escaped byte is decoded as a plain character, never re-escaped.
      c         = {esc_high, digit[3:0]};
      esc_phase = pebd_pkg::EscNone;
      esc_high  = '0;
    end else if (c == pebd_pkg::CharPercent) begin
      esc_phase = pebd_pkg::EscHigh;
      return;
    end
    six = sextet_value(c);
    if (six < 0) begin
      stop_decoding();
      return;
    end
    group_bits[23 - 6 * group_count -: 6] = six[5:0];
    group_count++;
    if (group_count == 4) begin
      push_group_bytes(3);
      group_bits  = '0;
      group_count = 0;
    end
  endtask

  task automatic add_byte(logic [7:0] c);
    pending_chars.push_back('{ch: c, eos: 1'b0});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_eos();
    pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1});
  endtask

  task automatic add_escaped(logic [7:0] c, bit broken);
    logic [7:0] bad;
    bad = 8'($urandom_range(0, 255));
    while (hex_value(bad) >= 0) bad = 8'($urandom_range(0, 255));
    add_byte(pebd_pkg::CharPercent);
    add_byte(broken && $urandom_range(0, 1) ? bad : hex_char(c[7:4], $urandom_range(0, 1)));
    add_byte(broken ? bad : hex_char(c[3:0], $urandom_range(0, 1)));
  endtask

  // One string: mostly valid base64 with some escapes, at times ended by padding, junk or a cut escape.
  task automatic add_random_string();
    int len;
    int r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) add_byte(8'($urandom_range(0, 255)));
      else if (r < 20) add_escaped(base64_char($urandom_range(0, 63)), r < 5);
      else add_byte(base64_char($urandom_range(0, 63)));
    end
    r = $urandom_range(0, 99);
    if (r >= 60 && r < 80) begin
      add_byte(pebd_pkg::CharEquals);
      if (r < 70) add_byte(pebd_pkg::CharEquals);
    end else if (r >= 80 && r < 90) begin
      add_byte(8'($urandom_range(0, 255)));
      add_byte(base64_char($urandom_range(0, 63)));
    end else if (r >= 90) begin
      add_byte(pebd_pkg::CharPercent);
      if (r >= 95) add_byte(hex_char($urandom_range(0, 15), r[0]));
    end
    add_eos();
  endtask

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    $display("tb: mismatch on %s, expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  task automatic check_result();
    decoded_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected result beat", 8'h00, out_byte_o);
      return;
    end
    want = expected_bytes.pop_front();
    if (out_byte_o !== want.data) report_mismatch("out_byte", want.data, out_byte_o);
    if (byte_valid_o !== want.valid) report_mismatch("byte_valid", want.valid, byte_valid_o);
    if (last_of_run_o !== want.last) report_mismatch("last_of_run", want.last, last_of_run_o);
    if (stream_done_o !== want.done) report_mismatch("stream_done", want.done, stream_done_o);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Input side: a beat is predicted when accepted, and the next one follows after a random gap, possibly none.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_beat(in_char_i, end_of_string_i);
        beats_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          in_char_i       <= pending_chars[0].ch;
          end_of_string_i <= pending_chars[0].eos;
          void'(pending_chars.pop_front());
          in_valid_i      <= 1'b1;
          send_gap = idle_length(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each accepted result beat and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        recv_hold = idle_length(recv_calm);
        out_ready_i <= (recv_hold == 0);
      end
    end
  end

  initial begin
    clear_group();
    stopped = 1'b0;
    // Directed part: a full group with an escape, sextet extremes, padding, junk after a stop,
    // a stop with one character held, an escape cut by end of string, a bad and a '%' escape.
    add_text("zW%46/");
    add_eos();
    add_text("A/%2b=");
    add_byte(8'hFF);
    add_eos();
    add_text("Q");
    add_byte(8'h00);
    add_eos();
    add_text("QU%4");
    add_eos();
    add_text("%G");
    add_eos();
    add_text("%25");
    add_eos();
    total_beats = 230;
    while (pending_chars.size() < total_beats) add_random_string();
    total_beats = pending_chars.size();

    while (beats_accepted < total_beats) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
